// ===== rtl/core/rotation_to_axis_angle_defines.svh =====
// Assertion macros used by the checker file rta_checker.sv.
`ifndef ROTATION_TO_AXIS_ANGLE_DEFINES_SVH
`define ROTATION_TO_AXIS_ANGLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RTA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define RTA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/rta_pkg.sv =====
package rta_pkg;

	localparam int IN_W  = 240;
	localparam int OUT_W = 144;

	// stage map of the pipeline
	localparam int ST_PREP  = 1;
	localparam int ST_INIT  = 2;
	localparam int SQ_FIRST = 3;
	localparam int SQ_LAST  = 28;
	localparam int ND_FIRST = 3;
	localparam int ND_LAST  = 38;
	localparam int CR_INIT  = 29;
	localparam int CR_FIRST = 30;
	localparam int CR_LAST  = 59;
	localparam int NQ_FIRST = 39;
	localparam int NQ_LAST  = 56;
	localparam int ST_CLAMP = 60;
	localparam int ST_MUL   = 61;
	localparam int ST_RND   = 62;
	localparam int GD_FIRST = 63;
	localparam int GD_LAST  = 79;
	localparam int ST_OUT   = 80;
	localparam int NS       = 80;

	localparam int ONE_Q24        = 16777216;
	localparam int NEAR_PI_LIMIT  = 1678;
	localparam logic [31:0] TINY_THETA = 32'd11;
	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;

	localparam logic [31:0] ATAN_TAB [0:29] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	// digit-by-digit square root state, radicand consumed from the top
	typedef struct packed {
		logic [51:0] rad;
		logic [29:0] rem;
		logic [25:0] root;
	} isq_t;

	typedef struct packed {
		logic [31:0]       shx;
		logic [31:0]       shy;
		logic [31:0]       shz;
		logic [2:0][17:0]  d;
		logic [2:0][15:0]  dg;
		logic [27:0]       c;
		logic              npi;
		logic [2:0][31:0]  sq;
		isq_t              ssq;
		logic [2:0][28:0]  e;
		logic [26:0]       den;
		logic [2:0][58:0]  nrem;
		logic [2:0][35:0]  nq;
		isq_t [2:0]        nsq;
		logic [31:0]       cx;
		logic [31:0]       cy;
		logic [33:0]       ang;
		logic              szero;
		logic              cneg;
		logic [31:0]       theta;
		logic [2:0][47:0]  gprod;
		logic [2:0][49:0]  nprod;
		logic [2:0][48:0]  grem;
		logic [2:0][16:0]  gq;
		logic [2:0][17:0]  nm;
		logic [2:0][15:0]  aa;
	} pipe_t;

endpackage

// ===== rtl/core/rotation_to_axis_angle.sv =====
// Rotation to theta-u converter for rigid 3x4 transforms.
// Input channel s_axis: one item is one transform, nine Q2.14 rotation
// entries and a Q16.16 translation. Output channel m_axis: the translation
// unchanged plus the theta-u rotation vector in Q3.13, saturated.
// Throughput: one item per cycle in both directions while m_axis_tready stays high.
// From acceptance to m_axis_tvalid an item passes through 80 pipeline stages
// (square root, CORDIC atan2, two banks of restoring dividers, a second
// square root) and one output register.
// Reset (arst_n low) clears the stage valid bits, the output register and
// the skid register; items in flight are dropped, payload is left as is.
// Stall: the output register holds its item while m_axis_tready is low; the
// pipeline keeps moving into a one-item skid register, and only when that
// fills does s_axis_tready drop and the whole pipeline freeze. Nothing is
// lost or repeated. s_axis_tready comes straight from a flop.
module rotation_to_axis_angle (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// rot_r0_c0, rot_r0_c1, rot_r0_c2, rot_r1_c0, rot_r1_c1, rot_r1_c2,
	// rot_r2_c0, rot_r2_c1, rot_r2_c2 (16 each), shift_x, shift_y, shift_z (32 each)
	input  logic [rta_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// out_shift_x, out_shift_y, out_shift_z (32 each),
	// axis_angle_x, axis_angle_y, axis_angle_z (16 each)
	output logic [rta_pkg::OUT_W-1:0] m_axis_tdata
);
	import rta_pkg::*;

	pipe_t             in_c;
	pipe_t             pl_s [1:NS];
	logic [NS:1]       vld_s;
	logic              en;
	logic              emit;
	logic              out_v_q;
	logic              skid_v_q;
	logic [OUT_W-1:0]  out_d_q;
	logic [OUT_W-1:0]  skid_d_q;
	logic [OUT_W-1:0]  res_c;

	// one step of the square root: bring down two bits, try root*4+1
	function automatic isq_t isq_step(isq_t a);
		logic [29:0] cur;
		logic [29:0] trial;
		isq_t        r;
		cur    = {a.rem[27:0], a.rad[51:50]};
		trial  = {2'b00, a.root, 2'b01};
		r.rad  = {a.rad[49:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {a.root[24:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[24:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [15:0] mag16(logic [17:0] v);
		logic [17:0] n;
		n = -v;
		return v[17] ? n[15:0] : v[15:0];
	endfunction

	// unpack the item; skew differences and (trace-1)/2 in Q24
	always_comb begin
		logic [15:0] r [0:8];
		for (int i = 0; i < 9; i++) begin
			r[i] = s_axis_tdata[16*i +: 16];
		end
		in_c     = '0;
		in_c.shx = s_axis_tdata[175:144];
		in_c.shy = s_axis_tdata[207:176];
		in_c.shz = s_axis_tdata[239:208];
		in_c.d[0] = 18'($signed(r[7])) - 18'($signed(r[5]));
		in_c.d[1] = 18'($signed(r[2])) - 18'($signed(r[6]));
		in_c.d[2] = 18'($signed(r[3])) - 18'($signed(r[1]));
		in_c.dg[0] = r[0];
		in_c.dg[1] = r[4];
		in_c.dg[2] = r[8];
		in_c.c = 28'(($signed(r[0]) + $signed(r[4]) + $signed(r[8]) - 16384) * 512);
	end

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	for (genvar k = 1; k <= NS; k++) begin : g_st
		localparam int DI = (k >= ND_FIRST && k <= ND_LAST) ? ND_LAST - k : 0;
		localparam int CJ = (k >= CR_FIRST && k <= CR_LAST) ? k - CR_FIRST : 0;
		localparam int GI = (k >= GD_FIRST && k <= GD_LAST) ? GD_LAST - k : 0;
		pipe_t pv;
		pipe_t nx;

		if (k == 1) begin : g_a
			assign pv = in_c;
		end else begin : g_b
			assign pv = pl_s[k-1];
		end

		always_comb begin
			logic [63:0]        trial;
			logic signed [31:0] xs;
			logic signed [31:0] ys;
			logic [33:0]        sum;
			logic [50:0]        rnd;
			logic [15:0]        ad;
			logic [18:0]        mag;
			logic [18:0]        nmag;
			nx    = pv;
			trial = '0;
			xs    = '0;
			ys    = '0;
			sum   = '0;
			rnd   = '0;
			ad    = '0;
			mag   = '0;
			nmag  = '0;

			if (k == ST_PREP) begin
				for (int m = 0; m < 3; m++) begin
					nx.sq[m] = 32'($signed(pv.d[m]) * $signed(pv.d[m]));
					nx.e[m]  = 29'($signed(pv.dg[m]) * 1024 - int'($signed(pv.c)));
				end
				nx.den = 27'(ONE_Q24 - int'($signed(pv.c)));
				nx.npi = (int'($signed(pv.c)) + ONE_Q24) < NEAR_PI_LIMIT;
			end

			if (k == ST_INIT) begin
				sum = 34'(pv.sq[0]) + 34'(pv.sq[1]) + 34'(pv.sq[2]);
				nx.ssq.rad  = {sum, 18'b0};
				nx.ssq.rem  = '0;
				nx.ssq.root = '0;
				for (int m = 0; m < 3; m++) begin
					nx.nrem[m] = ($signed(pv.e[m]) > 0) ? {pv.e[m][26:0], 32'b0} : '0;
					nx.nq[m]   = '0;
					nx.nsq[m]  = '0;
				end
			end

			if (k >= SQ_FIRST && k <= SQ_LAST) begin
				nx.ssq = isq_step(pv.ssq);
			end

			// near-pi quotient e*2^32 / (1-c), one bit per stage
			if (k >= ND_FIRST && k <= ND_LAST) begin
				trial = 64'(pv.den) << DI;
				for (int m = 0; m < 3; m++) begin
					if (64'(pv.nrem[m]) >= trial) begin
						nx.nrem[m]     = pv.nrem[m] - trial[58:0];
						nx.nq[m][DI]   = 1'b1;
					end
					if (k == ND_LAST) begin
						nx.nsq[m].rad = {nx.nq[m], 16'b0};
					end
				end
			end

			if (k >= NQ_FIRST && k <= NQ_LAST) begin
				for (int m = 0; m < 3; m++) begin
					nx.nsq[m] = isq_step(pv.nsq[m]);
				end
			end

			// atan2 set-up: left half-plane turned by -90 degrees
			if (k == CR_INIT) begin
				nx.szero = (pv.ssq.root == '0);
				nx.cneg  = pv.c[27];
				if (pv.c[27]) begin
					nx.cx  = {6'b0, pv.ssq.root};
					nx.cy  = 32'(-int'($signed(pv.c)));
					nx.ang = HALF_PI_Q30;
				end else begin
					nx.cx  = {{4{pv.c[27]}}, pv.c};
					nx.cy  = {6'b0, pv.ssq.root};
					nx.ang = '0;
				end
			end

			if (k >= CR_FIRST && k <= CR_LAST) begin
				xs = $signed(pv.cx) >>> CJ;
				ys = $signed(pv.cy) >>> CJ;
				if (!pv.cy[31]) begin
					nx.cx  = pv.cx + ys;
					nx.cy  = pv.cy - xs;
					nx.ang = pv.ang + 34'(ATAN_TAB[CJ]);
				end else begin
					nx.cx  = pv.cx - ys;
					nx.cy  = pv.cy + xs;
					nx.ang = pv.ang - 34'(ATAN_TAB[CJ]);
				end
			end

			if (k == ST_CLAMP) begin
				if (pv.szero) begin
					nx.theta = pv.cneg ? PI_Q30[31:0] : '0;
				end else if (pv.ang[33]) begin
					nx.theta = '0;
				end else if (pv.ang > PI_Q30) begin
					nx.theta = PI_Q30[31:0];
				end else begin
					nx.theta = pv.ang[31:0];
				end
			end

			if (k == ST_MUL) begin
				for (int m = 0; m < 3; m++) begin
					ad = mag16(pv.d[m]);
					nx.gprod[m] = ad * pv.theta;
					nx.nprod[m] = pv.theta * pv.nsq[m].root[17:0];
				end
			end

			// rounding offset s*128 = den/2 folded into the dividend
			if (k == ST_RND) begin
				for (int m = 0; m < 3; m++) begin
					nx.grem[m] = 49'(pv.gprod[m]) + 49'({pv.ssq.root, 7'b0});
					nx.gq[m]   = '0;
					rnd        = {1'b0, pv.nprod[m]} + (51'd1 << 32);
					nx.nm[m]   = rnd[50:33];
				end
			end

			if (k >= GD_FIRST && k <= GD_LAST) begin
				trial = 64'({pv.ssq.root, 8'b0}) << GI;
				for (int m = 0; m < 3; m++) begin
					if (64'(pv.grem[m]) >= trial) begin
						nx.grem[m]   = pv.grem[m] - trial[48:0];
						nx.gq[m][GI] = 1'b1;
					end
				end
			end

			if (k == ST_OUT) begin
				for (int m = 0; m < 3; m++) begin
					ad = mag16(pv.d[m]);
					if (pv.npi) begin
						mag = 19'(pv.nm[m]);
					end else if (pv.theta < TINY_THETA) begin
						mag = 19'((17'(ad) + 17'd2) >> 2);
					end else if (pv.szero) begin
						mag = '0;
					end else begin
						mag = 19'(pv.gq[m]);
					end
					nmag = -mag;
					if (pv.d[m][17]) begin
						nx.aa[m] = (mag > 19'd32768) ? 16'h8000 : nmag[15:0];
					end else begin
						nx.aa[m] = (mag > 19'd32767) ? 16'h7FFF : mag[15:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_s[k] <= nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], s_axis_tvalid};
		end
	end

	assign emit  = en && vld_s[NS];
	assign res_c = {pl_s[NS].aa[2], pl_s[NS].aa[1], pl_s[NS].aa[0],
	                pl_s[NS].shz, pl_s[NS].shy, pl_s[NS].shx};

	// output register with a one-item skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			out_v_q  <= skid_v_q || emit;
			skid_v_q <= 1'b0;
		end else if (emit) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_d_q <= skid_v_q ? skid_d_q : res_c;
		end else if (emit) begin
			skid_d_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;

endmodule

// ===== rtl/core/rta_checker.sv =====
`include "rotation_to_axis_angle_defines.svh"

module rta_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [rta_pkg::OUT_W-1:0] m_axis_tdata
);
	import rta_pkg::*;

	logic [7:0] inflight_q;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 8'(s_axis_tvalid && s_axis_tready)
			              - 8'(m_axis_tvalid && m_axis_tready);
		end
	end

	`RTA_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`RTA_IMPLY(a_no_spurious, m_axis_tvalid, inflight_q != 8'd0, "result without an item in flight")
	`RTA_IMPLY(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with output empty")
	`RTA_IMPLY(a_depth, 1'b1, inflight_q <= 8'(NS + 2), "more items in flight than storage")

endmodule

bind rotation_to_axis_angle rta_checker u_rta_checker (.*);

// ===== sim/axis_angle_checker.sv =====
`timescale 1ns / 100ps

module axis_angle_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [239:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [143:0] m_axis_tdata,
	output int           fail_count,
	output int           pending,
	output int           result_count
);

	logic [143:0] expected_poses [$];

	initial begin
		fail_count   = 0;
		pending      = 0;
		result_count = 0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic [15:0] sat_q13(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// CORDIC vectoring atan2, Q30 radians, clamped to [0, pi]
	function automatic longint angle_q30(longint y, longint x);
		longint ang;
		longint xs;
		longint ys;
		longint t;
		ang = 0;
		if (y == 0)
			return (x < 0) ? longint'(rta_pkg::PI_Q30) : 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			ang = longint'(rta_pkg::HALF_PI_Q30);
		end
		for (int i = 0; i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				ang += longint'(rta_pkg::ATAN_TAB[i]);
			end else begin
				x -= ys;
				y += xs;
				ang -= longint'(rta_pkg::ATAN_TAB[i]);
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > longint'(rta_pkg::PI_Q30))
			ang = longint'(rta_pkg::PI_Q30);
		return ang;
	endfunction

	function automatic logic [143:0] predict_pose(logic [239:0] t);
		longint r [9];
		longint d [3];
		longint diag [3];
		longint comp [3];
		longint c;
		longint s;
		longint theta;
		longint e;
		longint m;
		longint unsigned sum;
		longint unsigned den;
		longint unsigned q;
		longint unsigned rt;
		for (int k = 0; k < 9; k++)
			r[k] = longint'($signed(t[16*k +: 16]));
		d[0] = r[7] - r[5];
		d[1] = r[2] - r[6];
		d[2] = r[3] - r[1];
		diag[0] = r[0];
		diag[1] = r[4];
		diag[2] = r[8];
		sum = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
		s = longint'(int_sqrt(sum << 18));
		c = (r[0] + r[4] + r[8] - 16384) * 512;
		theta = angle_q30(s, c);
		if (c + rta_pkg::ONE_Q24 >= rta_pkg::NEAR_PI_LIMIT) begin
			for (int k = 0; k < 3; k++) begin
				if (theta < 11)
					comp[k] = round_div(d[k], 4);
				else if (s == 0)
					comp[k] = 0;        // zero skew, sinc undefined
				else
					comp[k] = round_div(d[k] * theta, s * 256);
			end
		end else begin
			den = longint'(rta_pkg::ONE_Q24) - c;
			for (int k = 0; k < 3; k++) begin
				e = diag[k] * 1024 - c;
				m = 0;
				if (e > 0) begin
					q  = (longint'(e) << 32) / den;
					rt = int_sqrt(q);
					m  = longint'((longint'(theta) * rt + (64'd1 << 32)) >> 33);
				end
				comp[k] = (d[k] < 0) ? -m : m;
			end
		end
		return {sat_q13(comp[2]), sat_q13(comp[1]), sat_q13(comp[0]),
			t[239:208], t[207:176], t[175:144]};
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%h, got 0x%h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		logic [143:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_poses.insert(expected_poses.size(), predict_pose(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				result_count++;
				if (expected_poses.size() == 0) begin
					$error("unexpected result 0x%h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_poses.pop_front();
					check_field("out_shift_x", want[31:0], m_axis_tdata[31:0]);
					check_field("out_shift_y", want[63:32], m_axis_tdata[63:32]);
					check_field("out_shift_z", want[95:64], m_axis_tdata[95:64]);
					check_field("axis_angle_x", {16'd0, want[111:96]},
						{16'd0, m_axis_tdata[111:96]});
					check_field("axis_angle_y", {16'd0, want[127:112]},
						{16'd0, m_axis_tdata[127:112]});
					check_field("axis_angle_z", {16'd0, want[143:128]},
						{16'd0, m_axis_tdata[143:128]});
				end
			end
			pending = expected_poses.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the rotation to theta-u converter.
// Inputs change on the falling edge; the checker samples on the rising edge.
module testbench;

	localparam int WATCHDOG_LIMIT = 5000;   // long receiver hold plus pipeline depth, many times over
	localparam int RANDOM_POSES   = 500;
	localparam int HOLD_CYCLES    = 300;    // far longer than the 81-deep pipe
	localparam real PI            = 3.14159265358979;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [239:0] s_axis_tdata;    // r00..r22 (16 each), shift_x/y/z (32 each)
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;    // out_shift_x/y/z (32 each), axis_angle_x/y/z (16 each)

	int  fail_count;
	int  pending;
	int  result_count;
	int  poses_sent;
	int  quiet_cycles;
	bit  tx_idle_on;
	bit  rx_idle_on;
	bit  long_hold_go;
	bit  long_hold_done;

	rotation_to_axis_angle dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	axis_angle_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.result_count  (result_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: any stretch with no handshake on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request, none at the end
	initial begin
		int burst;
		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_go && !long_hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold_done = 1'b1;
				m_axis_tready = 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 13);
				m_axis_tready = 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	function automatic logic [15:0] q14(real v);
		int i;
		i = $rtoi(v * 16384.0 + ((v < 0) ? -0.5 : 0.5));
		if (i > 32767)
			i = 32767;
		if (i < -32768)
			i = -32768;
		return i[15:0];
	endfunction

	function automatic real uniform01();
		return real'($urandom) / 4294967296.0;
	endfunction

	// rows r0..r2, packed r00 in the lowest bits
	function automatic logic [143:0] rot_entries(logic [15:0] r00, logic [15:0] r01,
		logic [15:0] r02, logic [15:0] r10, logic [15:0] r11, logic [15:0] r12,
		logic [15:0] r20, logic [15:0] r21, logic [15:0] r22);
		return {r22, r21, r20, r12, r11, r10, r02, r01, r00};
	endfunction

	// Rodrigues form of a rotation about a random axis, optional jitter per entry
	function automatic logic [143:0] random_rotation(real angle, int jitter);
		real u [3];
		real n;
		real cs;
		real sn;
		real m [9];
		logic [143:0] packed_rot;
		logic [15:0] e;
		do begin
			for (int k = 0; k < 3; k++)
				u[k] = uniform01() * 2.0 - 1.0;
			n = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
		end while (n < 0.05);
		for (int k = 0; k < 3; k++)
			u[k] = u[k] / n;
		cs = $cos(angle);
		sn = $sin(angle);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[3 * i + j] = (1.0 - cs) * u[i] * u[j] + ((i == j) ? cs : 0.0);
		m[1] -= sn * u[2];
		m[3] += sn * u[2];
		m[2] += sn * u[1];
		m[6] -= sn * u[1];
		m[5] -= sn * u[0];
		m[7] += sn * u[0];
		for (int k = 0; k < 9; k++) begin
			e = q14(m[k]);
			if (jitter > 0)
				e = e + 16'($urandom_range(0, 2 * jitter)) - 16'(jitter);
			packed_rot[16 * k +: 16] = e;
		end
		return packed_rot;
	endfunction

	task automatic send_pose(logic [143:0] rot);
		int gap;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {32'($urandom), 32'($urandom), 32'($urandom), rot};
		do
			@(posedge clk);
		while (!s_axis_tready);
		poses_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	function automatic logic [143:0] random_pose();
		int pick;
		real angle;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			angle = uniform01() * PI;
		else if (pick < 45)
			angle = PI - uniform01() * 0.02;        // near pi branch
		else if (pick < 55)
			angle = uniform01() * 1.0e-3;           // tiny angle
		if (pick < 55)
			return random_rotation(angle, 0);
		if (pick < 75)
			return random_rotation(uniform01() * PI, $urandom_range(1, 200));
		return {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom)};
	endfunction

	localparam logic [15:0] P1 = 16'sd16384;
	localparam logic [15:0] M1 = -16'sd16384;
	localparam logic [15:0] Z0 = 16'd0;
	localparam logic [15:0] MX = 16'h7FFF;
	localparam logic [15:0] MN = 16'h8000;

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		poses_sent    = 0;
		quiet_cycles  = 0;
		tx_idle_on    = 1'b0;
		rx_idle_on    = 1'b0;
		long_hold_go  = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: identity, half turns, quarter turns, tiny turns, zero skew
		// with negative cosine, degenerate and saturating matrices
		send_pose(rot_entries(P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1));
		send_pose(rot_entries(P1, Z0, Z0, Z0, M1, Z0, Z0, Z0, M1));
		send_pose(rot_entries(M1, Z0, Z0, Z0, P1, Z0, Z0, Z0, M1));
		send_pose(rot_entries(M1, Z0, Z0, Z0, M1, Z0, Z0, Z0, P1));
		send_pose(rot_entries(M1, 16'd3, Z0, 16'hFFFD, M1, 16'd2, Z0, 16'hFFFE, P1));
		send_pose(rot_entries(Z0, M1, Z0, P1, Z0, Z0, Z0, Z0, P1));
		send_pose(rot_entries(Z0, P1, Z0, M1, Z0, Z0, Z0, Z0, P1));
		send_pose(rot_entries(P1, Z0, Z0, Z0, Z0, M1, Z0, P1, Z0));
		send_pose(rot_entries(Z0, Z0, P1, Z0, P1, Z0, M1, Z0, Z0));
		send_pose(rot_entries(P1, Z0, Z0, 16'd1, P1, Z0, Z0, Z0, P1));
		send_pose(rot_entries(P1, 16'd1, Z0, Z0, P1, Z0, Z0, Z0, P1));
		send_pose(rot_entries(Z0, Z0, Z0, Z0, Z0, Z0, Z0, Z0, Z0));
		send_pose(rot_entries(MX, MX, MX, MX, MX, MX, MX, MX, MX));
		send_pose(rot_entries(MN, MN, MN, MN, MN, MN, MN, MN, MN));
		send_pose(rot_entries(MN, MX, MN, MN, MN, MX, MX, MN, MN));
		send_pose(rot_entries(MN, MN, MX, MX, MN, MN, MN, MX, MN));
		send_pose(rot_entries(MX, MN, MX, MX, MX, MN, MN, MX, MX));
		send_pose(random_rotation(PI, 0));
		send_pose(random_rotation(PI - 1.0e-3, 0));
		send_pose(random_rotation(PI / 2.0, 0));
		send_pose(random_rotation(1.0e-9, 0));

		// sender waits for everything to come back
		drain_results();

		// receiver holds off while the sender keeps offering items
		long_hold_go = 1'b1;
		for (int i = 0; i < 150; i++)
			send_pose(random_pose());
		drain_results();

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int i = 0; i < RANDOM_POSES - 200; i++)
			send_pose(random_pose());

		// closing stretch at full rate on both sides
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_pose(random_pose());
		drain_results();
		repeat (100) @(negedge clk);

		$display("%0d transforms sent, %0d results checked", poses_sent, result_count);
		$display("covered: axis extremes, half turns, tiny angles, noisy and raw matrices");
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rta_pkg.sv
rtl/core/rotation_to_axis_angle.sv
rtl/core/rta_checker.sv
sim/axis_angle_checker.sv
sim/testbench.sv
